// ----- hdl/sha1_pkg.sv -----
// Shared types and constants of the SHA-1 hash engine.
// Used by sha1_ctrl, sha1_datapath and sha1_hash_engine; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned Rounds = 80;

	localparam logic [WordW-1:0] K_CH   = 32'h5a827999;
	localparam logic [WordW-1:0] K_PAR1 = 32'h6ed9eba1;
	localparam logic [WordW-1:0] K_MAJ  = 32'h8f1bbcdc;
	localparam logic [WordW-1:0] K_PAR2 = 32'hca62c1d6;

	localparam logic [WordW-1:0] IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0]       PAD_BYTE  = 8'h80;
	localparam logic [WordW-1:0] PAD_WHOLE = {PAD_BYTE, 24'h0};

	// source of the word written into the schedule
	typedef enum logic [2:0] {
		SEL_INPUT,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN_HI,
		SEL_LEN_LO
	} word_sel_t;

	// round function group, one per twenty rounds
	typedef enum logic [1:0] {
		GRP_CH,
		GRP_PAR1,
		GRP_MAJ,
		GRP_PAR2
	} round_grp_t;

	typedef struct packed {
		logic       put;
		word_sel_t  sel;
		logic       round;
		round_grp_t grp;
		logic       upd;
		logic       reload;
		logic [2:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic pos_14;
		logic pos_15;
		logic in_full;
	} status_t;

	function automatic logic [WordW-1:0] round_k(input round_grp_t g);
		logic [WordW-1:0] k;
		case (g)
			GRP_CH:   k = K_CH;
			GRP_PAR1: k = K_PAR1;
			GRP_MAJ:  k = K_MAJ;
			GRP_PAR2: k = K_PAR2;
			default:  k = K_CH;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/sha1_datapath.sv -----
// SHA-1 datapath: rolling schedule, working variables, chaining words, bit count.
// Driven by sha1_ctrl through sha1_pkg::cmd_t; uses sha1_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha1_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sha1_pkg::cmd_t                cmd,
	input  wire logic [sha1_pkg::WordW-1:0]    in_word,
	input  wire logic [2:0]                    in_bytes,
	input  wire logic                          in_last,
	output      sha1_pkg::status_t             stat,
	output      logic [sha1_pkg::WordW-1:0]    digest
);

	logic [sha1_pkg::WordW-1:0] w_q [16];
	logic [sha1_pkg::WordW-1:0] h_q [5];
	logic [sha1_pkg::WordW-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [3:0]                 pos_q;
	logic [63:0]                bitlen_q;

	logic [2:0]                 nbytes;
	logic [sha1_pkg::WordW-1:0] in_val;
	logic [sha1_pkg::WordW-1:0] put_val;
	logic [sha1_pkg::WordW-1:0] f_val;
	logic [sha1_pkg::WordW-1:0] t_val;
	logic [sha1_pkg::WordW-1:0] w_new;

	// a non-last word or an oversized count is a full word
	assign nbytes = (!in_last || in_bytes > 3'd4) ? 3'd4 : in_bytes;

	always_comb begin
		case (nbytes)
			3'd0:    in_val = sha1_pkg::PAD_WHOLE;
			3'd1:    in_val = {in_word[31:24], sha1_pkg::PAD_BYTE, 16'h0};
			3'd2:    in_val = {in_word[31:16], sha1_pkg::PAD_BYTE, 8'h0};
			3'd3:    in_val = {in_word[31:8], sha1_pkg::PAD_BYTE};
			default: in_val = in_word;
		endcase
	end

	always_comb begin
		case (cmd.sel)
			sha1_pkg::SEL_INPUT:  put_val = in_val;
			sha1_pkg::SEL_PAD:    put_val = sha1_pkg::PAD_WHOLE;
			sha1_pkg::SEL_LEN_HI: put_val = bitlen_q[63:32];
			sha1_pkg::SEL_LEN_LO: put_val = bitlen_q[31:0];
			default:              put_val = '0;
		endcase
	end

	always_comb begin
		case (cmd.grp)
			sha1_pkg::GRP_CH:  f_val = (b_q & c_q) | (~b_q & d_q);
			sha1_pkg::GRP_MAJ: f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default:           f_val = b_q ^ c_q ^ d_q;
		endcase
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + sha1_pkg::round_k(cmd.grp) + w_q[0];

	// w_q[i] holds W[t+i]; the new tap is W[t+16]
	logic [sha1_pkg::WordW-1:0] w_mix;
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};

	// schedule and working variables: payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.put || cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= cmd.put ? put_val : w_new;
		end
		if (cmd.put && pos_q == 4'd15) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bitlen_q <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sha1_pkg::IV[i];
			end
		end else begin
			if (cmd.put) begin
				pos_q <= pos_q + 4'd1;
			end
			if (cmd.put && cmd.sel == sha1_pkg::SEL_INPUT) begin
				bitlen_q <= bitlen_q + {58'h0, nbytes, 3'b000};
			end
			if (cmd.upd) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.reload) begin
				bitlen_q <= '0;
				pos_q    <= '0;
				for (int i = 0; i < 5; i++) begin
					h_q[i] <= sha1_pkg::IV[i];
				end
			end
		end
	end

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest = h_q[0];
			3'd1:    digest = h_q[1];
			3'd2:    digest = h_q[2];
			3'd3:    digest = h_q[3];
			3'd4:    digest = h_q[4];
			default: digest = '0;
		endcase
	end

	assign stat.pos_14  = (pos_q == 4'd14);
	assign stat.pos_15  = (pos_q == 4'd15);
	assign stat.in_full = (nbytes == 3'd4);

endmodule
`default_nettype wire

// ----- hdl/sha1_ctrl.sv -----
// SHA-1 controller: sequences word intake, padding, rounds, update and digest output.
// Drives sha1_datapath through sha1_pkg::cmd_t; uses sha1_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha1_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_last,
	output      logic              in_ready,
	output      logic              out_valid,
	output      logic              out_last,
	input  wire logic              out_ready,
	input  wire sha1_pkg::status_t stat,
	output      sha1_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_UPD,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [6:0] rnd_q;
	logic [2:0] idx_q;
	logic       padding_q;
	logic       pad_pend_q;
	logic       len_phase_q;
	logic       done_q;

	logic       in_fire;
	logic       out_fire;
	sha1_pkg::word_sel_t pad_sel;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_last  = out_valid && (idx_q == 3'd4);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_comb begin
		if (pad_pend_q) begin
			pad_sel = sha1_pkg::SEL_PAD;
		end else if (len_phase_q) begin
			pad_sel = sha1_pkg::SEL_LEN_LO;
		end else if (stat.pos_14) begin
			pad_sel = sha1_pkg::SEL_LEN_HI;
		end else begin
			pad_sel = sha1_pkg::SEL_ZERO;
		end
	end

	always_comb begin
		cmd.put     = in_fire || (state_q == ST_PAD);
		cmd.sel     = (state_q == ST_PAD) ? pad_sel : sha1_pkg::SEL_INPUT;
		cmd.round   = (state_q == ST_ROUND);
		cmd.upd     = (state_q == ST_UPD);
		cmd.reload  = out_fire && (idx_q == 3'd4);
		cmd.out_idx = idx_q;
		if (rnd_q < 7'd20) begin
			cmd.grp = sha1_pkg::GRP_CH;
		end else if (rnd_q < 7'd40) begin
			cmd.grp = sha1_pkg::GRP_PAR1;
		end else if (rnd_q < 7'd60) begin
			cmd.grp = sha1_pkg::GRP_MAJ;
		end else begin
			cmd.grp = sha1_pkg::GRP_PAR2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			idx_q       <= '0;
			padding_q   <= 1'b0;
			pad_pend_q  <= 1'b0;
			len_phase_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_last) begin
							padding_q  <= 1'b1;
							pad_pend_q <= stat.in_full;
						end
						if (stat.pos_15) begin
							state_q <= ST_ROUND;
						end else if (in_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					case (pad_sel)
						sha1_pkg::SEL_PAD:    pad_pend_q  <= 1'b0;
						sha1_pkg::SEL_LEN_HI: len_phase_q <= 1'b1;
						sha1_pkg::SEL_LEN_LO: done_q      <= 1'b1;
						default: ;
					endcase
					if (stat.pos_15) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (rnd_q == 7'(sha1_pkg::Rounds - 1)) begin
						rnd_q   <= '0;
						state_q <= ST_UPD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_UPD: begin
					if (done_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (padding_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						if (idx_q == 3'd4) begin
							idx_q       <= '0;
							padding_q   <= 1'b0;
							len_phase_q <= 1'b0;
							done_q      <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sha1_hash_engine.sv -----
// SHA-1 hash engine top level: stream ports, controller and datapath.
// Instantiates sha1_ctrl and sha1_datapath; uses sha1_pkg.
//
// Channel   Dir  Transaction    Payload
// s_axis    in   message word   s_tdata[31:0] message_word, [34:32] valid_bytes; s_tlast
// m_axis    out  digest word    m_tdata[31:0] digest_word; m_tlast digest_last
//
// A message word is taken while the engine is idle. Every sixteenth schedule word
// starts the 80 rounds of a 64-byte block and then one chaining update; a single
// round unit serves every round, and input is held off meanwhile.
// A last word is followed by its padding words (up to 17, with a second block if
// needed) and then five digest transactions. Reset loads the initial chaining values.
// Input is held off from a last word until the fifth digest word is taken; a
// stalled digest word holds.
`timescale 1ns / 1ps
`default_nettype none
module sha1_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] message_word, [34:32] valid_bytes, rest zero
	input  wire logic        s_tlast,   // last_word
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [31:0] digest_word
	output      logic        m_tlast    // digest_last
);

	sha1_pkg::cmd_t    cmd;
	sha1_pkg::status_t stat;

	// sequence intake, padding and rounds; hold the digest while the sink stalls
	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// schedule window, round logic and chaining words
	sha1_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (s_tdata[31:0]),
		.in_bytes (s_tdata[34:32]),
		.in_last  (s_tlast),
		.stat     (stat),
		.digest   (m_tdata)
	);

	// intake and digest output never overlap
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("intake open while digest is shown");

	// after the fifth digest word the engine is ready for a new message
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("engine not idle after digest");

	// a last word always leads into padding or rounds
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("intake open right after last word");

	// a non-last word never produces a digest in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
		else $error("digest after non-last word");

endmodule
`default_nettype wire
